// ===== design/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the next cycle, off while reset is high
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// same-cycle implication, off while reset is high
`define ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication checked in the next cycle, never disabled
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/slc_pkg.sv =====
// shared types and constants of the single-link clustering block
package slc_pkg;

   typedef enum logic [3:0] {
      S_LOAD,
      S_SRCH,
      S_SDRN,
      S_MERG,
      S_MDRN,
      S_LINIT,
      S_LCHK,
      S_LRD1,
      S_LRD2,
      S_LRD3,
      S_LSWP,
      S_LSDR,
      S_OUT
   } state_type;

   localparam logic CSR_NUM_DOCS = 1'b0;
   localparam logic CSR_TARGET   = 1'b1;

endpackage

// ===== design/single_link_clustering_core.sv =====
// top level of the single-link hierarchical clustering block
//
// usage: write num_docs (csr index 0) and target_clusters (csr index 1) while idle,
// then feed items with start while busy is low. operation 0 items load the
// document ids in order, operation 1 items load the strict lower-triangle
// distances row by row: (1,0), (2,0), (2,1), ... out-of-phase items are dropped.
// writing num_docs abandons a partly loaded job.
// the load can take a new item with every start. the item that completes the
// load starts the clustering run and raises busy. each of the n-1 rounds scans
// all pairs through one memory read port and folds a row with a min unit over
// both read ports. label relabeling sweeps all labels once per applied merge,
// after a label init.
// the results then stream out on rsp_strobe, one document per cycle in
// document order, rsp_last on the final one; busy drops with the last result.
// results cannot be held off: the receiver takes each on its strobe cycle.
// reset (synchronous, active high) returns to the load phase with an empty
// load, num_docs 64, target_clusters 1 and no result pending. stores hold
// their contents over reset and are always written before they are read.
module single_link_clustering_core #(
   parameter int MAX_DOCS  = 64,
   parameter int DIST_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_operation,
   input  logic [31:0] req_doc_id,
   input  logic [15:0] req_distance,
   output logic        rsp_strobe,
   output logic [31:0] rsp_doc_id_res,
   output logic [5:0]  rsp_cluster_label,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [6:0]  csr_wdata
);
   import slc_pkg::*;

   localparam int IW    = $clog2(MAX_DOCS);
   localparam int CW    = $clog2(MAX_DOCS + 1);
   localparam int KW    = (CW > 7) ? CW : 7;
   localparam int DW    = (DIST_BITS < 16) ? DIST_BITS : 16;
   localparam int DEPTH = MAX_DOCS * MAX_DOCS;
   localparam int AW    = $clog2(DEPTH);
   localparam int PW    = (IW > 6) ? IW : 6;

   // distance store address of an unordered pair, larger index selects the row
   function automatic logic [AW-1:0] daddr(input logic [IW-1:0] a, input logic [IW-1:0] b);
      logic [IW-1:0] hi;
      logic [IW-1:0] lo;
      hi = (a > b) ? a : b;
      lo = (a > b) ? b : a;
      return AW'(hi) * AW'(MAX_DOCS) + AW'(lo);
   endfunction

   state_type state_ff, state_in;

   // configuration
   logic [6:0] num_docs_ff, target_ff;

   // load tracking
   logic [CW-1:0] id_cnt_ff, id_cnt_in;
   logic          ph_dist_ff, ph_dist_in;
   logic [IW-1:0] row_ff, row_in, col_ff, col_in;

   // sequencer counters
   logic [IW-1:0] i_ff, i_in, j_ff, j_in, idx_ff, idx_in, rnd_ff, rnd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [MAX_DOCS-1:0] merged_ff, merged_in;

   // round minimum
   logic          found_ff, found_in;
   logic [DW-1:0] best_ff, best_in;
   logic [IW-1:0] bi_ff, bi_in, bj_ff, bj_in;

   // pipeline tags behind the registered memory reads
   logic          s_vld_ff, s_vld_in, m_vld_ff, m_vld_in, w_vld_ff, w_vld_in;
   logic [IW-1:0] s_i_ff, s_i_in, s_j_ff, s_j_in, m_k_ff, m_k_in, w_x_ff, w_x_in;
   logic [IW-1:0] keep_ff, keep_in, gone_ff, gone_in;
   logic          o_vld_ff, o_vld_in, o_last_ff, o_last_in;

   // memories and their port signals
   logic [DW-1:0]     dist_mem [DEPTH];
   logic [DW-1:0]     dq_a_ff, dq_b_ff, d_wdata;
   logic [AW-1:0]     d_waddr, d_raddr_a, d_raddr_b;
   logic              d_we;
   logic [31:0]       id_mem [MAX_DOCS];
   logic [31:0]       id_q_ff;
   logic [IW-1:0]     id_waddr, id_raddr;
   logic              id_we;
   logic [2*IW-1:0]   ml_mem [MAX_DOCS-1];
   logic [2*IW-1:0]   ml_q_ff;
   logic              ml_we;
   logic [IW-1:0]     lab_mem [MAX_DOCS];
   logic [IW-1:0]     lab_q_ff, lab_waddr, lab_wdata, lab_raddr;
   logic              lab_we;

   logic [KW-1:0] nd_ext, n_k;
   logic [CW-1:0] n, nm1;
   logic          accept, load_done, idx_last;
   logic [PW-1:0] lab_ext;

   // effective document count, zero acts as one, clipped to the store size
   assign nd_ext = KW'(num_docs_ff);
   assign n_k    = (nd_ext == '0) ? KW'(1) :
                   ((nd_ext > KW'(MAX_DOCS)) ? KW'(MAX_DOCS) : nd_ext);
   assign n      = CW'(n_k);
   assign nm1    = n - CW'(1);

   assign busy     = (state_ff != S_LOAD);
   assign accept   = start && !busy;
   assign idx_last = (CW'(idx_ff) == nm1);

   always_comb begin
      state_in   = state_ff;
      id_cnt_in  = id_cnt_ff;
      ph_dist_in = ph_dist_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      idx_in     = idx_ff;
      rnd_in     = rnd_ff;
      cnt_in     = cnt_ff;
      merged_in  = merged_ff;
      found_in   = found_ff;
      best_in    = best_ff;
      bi_in      = bi_ff;
      bj_in      = bj_ff;
      s_vld_in   = 1'b0;
      s_i_in     = i_ff;
      s_j_in     = j_ff;
      m_vld_in   = 1'b0;
      m_k_in     = idx_ff;
      w_vld_in   = 1'b0;
      w_x_in     = idx_ff;
      keep_in    = keep_ff;
      gone_in    = gone_ff;
      o_vld_in   = 1'b0;
      o_last_in  = 1'b0;
      d_we       = 1'b0;
      d_waddr    = daddr(row_ff, col_ff);
      d_wdata    = DW'(req_distance);
      d_raddr_a  = daddr(i_ff, j_ff);
      d_raddr_b  = daddr(bj_ff, idx_ff);
      id_we      = 1'b0;
      id_waddr   = id_cnt_ff[IW-1:0];
      id_raddr   = idx_ff;
      ml_we      = 1'b0;
      lab_we     = 1'b0;
      lab_waddr  = idx_ff;
      lab_wdata  = idx_ff;
      lab_raddr  = idx_ff;
      load_done  = 1'b0;

      unique case (state_ff)
         S_LOAD: begin
            if (accept && !req_operation && !ph_dist_ff) begin
               id_we     = 1'b1;
               id_cnt_in = id_cnt_ff + CW'(1);
               if (id_cnt_ff + CW'(1) == n) begin
                  if (n == CW'(1)) begin
                     load_done = 1'b1;
                  end else begin
                     ph_dist_in = 1'b1;
                     row_in     = IW'(1);
                     col_in     = '0;
                  end
               end
            end else if (accept && req_operation && ph_dist_ff) begin
               d_we = 1'b1;
               if (CW'(col_ff) + CW'(1) == CW'(row_ff)) begin
                  col_in = '0;
                  if (CW'(row_ff) == nm1) begin
                     load_done = 1'b1;
                  end else begin
                     row_in = row_ff + IW'(1);
                  end
               end else begin
                  col_in = col_ff + IW'(1);
               end
            end
            if (load_done) begin
               id_cnt_in  = '0;
               ph_dist_in = 1'b0;
               merged_in  = '0;
               rnd_in     = '0;
               idx_in     = '0;
               if (n == CW'(1)) begin
                  state_in = S_LINIT;
               end else begin
                  state_in = S_SRCH;
                  i_in     = IW'(1);
                  j_in     = '0;
                  found_in = 1'b0;
               end
            end
         end
         S_SRCH: begin
            // pair scan, compare happens in the next cycle on the read data
            s_vld_in = !merged_ff[i_ff] && !merged_ff[j_ff];
            if (CW'(j_ff) + CW'(1) == CW'(i_ff)) begin
               if (CW'(i_ff) == nm1) begin
                  state_in = S_SDRN;
               end else begin
                  i_in = i_ff + IW'(1);
                  j_in = '0;
               end
            end else begin
               j_in = j_ff + IW'(1);
            end
         end
         S_SDRN: begin
            state_in = S_MERG;
            idx_in   = '0;
         end
         S_MERG: begin
            // fold row bi into row bj, min written back in the next cycle
            d_raddr_a = daddr(bi_ff, idx_ff);
            d_raddr_b = daddr(bj_ff, idx_ff);
            m_vld_in  = (idx_ff != bi_ff) && (idx_ff != bj_ff);
            if (idx_last) begin
               state_in = S_MDRN;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         S_MDRN: begin
            merged_in[bi_ff] = 1'b1;
            ml_we  = 1'b1;
            rnd_in = rnd_ff + IW'(1);
            if (CW'(rnd_ff) + CW'(1) == nm1) begin
               state_in = S_LINIT;
               idx_in   = '0;
            end else begin
               state_in = S_SRCH;
               i_in     = IW'(1);
               j_in     = '0;
               found_in = 1'b0;
            end
         end
         S_LINIT: begin
            lab_we = 1'b1;
            if (idx_last) begin
               state_in = S_LCHK;
               rnd_in   = '0;
               cnt_in   = n;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         S_LCHK: begin
            if ((CW'(rnd_ff) < nm1) && (KW'(cnt_ff) > KW'(target_ff))) begin
               state_in = S_LRD1;
            end else begin
               state_in = S_OUT;
               idx_in   = '0;
            end
         end
         S_LRD1: begin
            lab_raddr = ml_q_ff[2*IW-1:IW];
            state_in  = S_LRD2;
         end
         S_LRD2: begin
            keep_in   = lab_q_ff;
            lab_raddr = ml_q_ff[IW-1:0];
            state_in  = S_LRD3;
         end
         S_LRD3: begin
            gone_in  = lab_q_ff;
            idx_in   = '0;
            state_in = S_LSWP;
         end
         S_LSWP: begin
            w_vld_in = 1'b1;
            if (idx_last) begin
               state_in = S_LSDR;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         S_LSDR: begin
            rnd_in   = rnd_ff + IW'(1);
            cnt_in   = cnt_ff - CW'(1);
            state_in = S_LCHK;
         end
         S_OUT: begin
            o_vld_in  = 1'b1;
            o_last_in = idx_last;
            if (idx_last) begin
               state_in = S_LOAD;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase

      // search compare stage, strict less keeps the first pair on a tie
      if (s_vld_ff && (!found_ff || (dq_a_ff < best_ff))) begin
         found_in = 1'b1;
         best_in  = dq_a_ff;
         bi_in    = s_i_ff;
         bj_in    = s_j_ff;
      end

      // row fold write stage
      if (m_vld_ff) begin
         d_we    = 1'b1;
         d_waddr = daddr(bj_ff, m_k_ff);
         d_wdata = (dq_a_ff < dq_b_ff) ? dq_a_ff : dq_b_ff;
      end

      // relabel write stage
      if (w_vld_ff && (lab_q_ff == gone_ff)) begin
         lab_we    = 1'b1;
         lab_waddr = w_x_ff;
         lab_wdata = keep_ff;
      end

      // a new document count drops the partial load
      if (csr_we && (csr_index == CSR_NUM_DOCS)) begin
         id_cnt_in  = '0;
         ph_dist_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_LOAD;
         num_docs_ff <= 7'd64;
         target_ff   <= 7'd1;
         id_cnt_ff   <= '0;
         ph_dist_ff  <= 1'b0;
         merged_ff   <= '0;
         found_ff    <= 1'b0;
         s_vld_ff    <= 1'b0;
         m_vld_ff    <= 1'b0;
         w_vld_ff    <= 1'b0;
         o_vld_ff    <= 1'b0;
         o_last_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         id_cnt_ff  <= id_cnt_in;
         ph_dist_ff <= ph_dist_in;
         merged_ff  <= merged_in;
         found_ff   <= found_in;
         s_vld_ff   <= s_vld_in;
         m_vld_ff   <= m_vld_in;
         w_vld_ff   <= w_vld_in;
         o_vld_ff   <= o_vld_in;
         o_last_ff  <= o_last_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_NUM_DOCS: num_docs_ff <= csr_wdata;
               CSR_TARGET:   target_ff   <= csr_wdata;
               default:      ;
            endcase
         end
      end
   end

   // counters and payload registers
   always_ff @(posedge clock) begin
      row_ff  <= row_in;
      col_ff  <= col_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      idx_ff  <= idx_in;
      rnd_ff  <= rnd_in;
      cnt_ff  <= cnt_in;
      best_ff <= best_in;
      bi_ff   <= bi_in;
      bj_ff   <= bj_in;
      s_i_ff  <= s_i_in;
      s_j_ff  <= s_j_in;
      m_k_ff  <= m_k_in;
      w_x_ff  <= w_x_in;
      keep_ff <= keep_in;
      gone_ff <= gone_in;
   end

   // distance store, one write and two read ports
   always_ff @(posedge clock) begin
      if (d_we) begin
         dist_mem[d_waddr] <= d_wdata;
      end
      dq_a_ff <= dist_mem[d_raddr_a];
      dq_b_ff <= dist_mem[d_raddr_b];
   end

   // document id store
   always_ff @(posedge clock) begin
      if (id_we) begin
         id_mem[id_waddr] <= req_doc_id;
      end
      id_q_ff <= id_mem[id_raddr];
   end

   // merge list, row in the upper half, column in the lower half
   always_ff @(posedge clock) begin
      if (ml_we) begin
         ml_mem[rnd_ff] <= {bi_ff, bj_ff};
      end
      ml_q_ff <= ml_mem[rnd_ff];
   end

   // label store
   always_ff @(posedge clock) begin
      if (lab_we) begin
         lab_mem[lab_waddr] <= lab_wdata;
      end
      lab_q_ff <= lab_mem[lab_raddr];
   end

   assign lab_ext           = PW'(lab_q_ff);
   assign rsp_strobe        = o_vld_ff;
   assign rsp_last          = o_last_ff;
   assign rsp_doc_id_res    = id_q_ff;
   assign rsp_cluster_label = lab_ext[5:0];

endmodule

// ===== design/slc_checker.sv =====
// port-level checker of the clustering block and its bind
`include "assert_macros.svh"

module slc_port_checker (
   input logic clock,
   input logic reset,
   input logic busy,
   input logic rsp_strobe,
   input logic rsp_last
);

   // result run is contiguous up to its last item
   `ASSERT_NEXT(a_run_contig, clock, reset, rsp_strobe && !rsp_last, rsp_strobe, "result run broken")

   // nothing follows the last item of a run
   `ASSERT_NEXT(a_run_end, clock, reset, rsp_strobe && rsp_last, !rsp_strobe, "item after last")

   // the block stays busy until the final item
   `ASSERT_NOW(a_busy_run, clock, reset, rsp_strobe && !rsp_last, busy, "idle during run")

   // reset leaves the block idle with no result
   `ASSERT_NEXT_ALWAYS(a_reset, clock, reset, !rsp_strobe && !busy, "bad state after reset")

endmodule

bind single_link_clustering_core slc_port_checker u_slc_port_checker (
   .clock      (clock),
   .reset      (reset),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_last   (rsp_last)
);
